// ===== rtl/tabular_q_learning_step_defines.svh =====
// assertion macros used by the checker file
// no dependencies; expects clk and rst_n in scope where used
`ifndef TABULAR_Q_LEARNING_STEP_DEFINES_SVH
`define TABULAR_Q_LEARNING_STEP_DEFINES_SVH

// same-cycle implication, ignored while reset is asserted
`define TQLS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tqls check failed");

// next-cycle implication, ignored while reset is asserted
`define TQLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tqls check failed");

`endif

// ===== rtl/tqls_pkg.sv =====
// types and constants of the tabular q-learning step block
// no dependencies
package tqls_pkg;

    localparam int KEY_W      = 41;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int COUNT_OUT_W = 13;

    localparam logic signed [15:0] OBS_LIMIT = 16'sd12288;
    localparam logic [15:0] Q_ONE = 16'd32768;

    localparam logic        TRAIN_MODE_RST    = 1'b1;
    localparam logic [15:0] LEARNING_RATE_RST = 16'd4915;
    localparam logic [15:0] DISCOUNT_RST      = 16'd32440;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TRAIN_MODE    = 2'd0,
        CFG_LEARNING_RATE = 2'd1,
        CFG_DISCOUNT      = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic signed [15:0] progress_obs;
        logic signed [15:0] vel_a_obs;
        logic signed [15:0] vel_b_obs;
        logic signed [15:0] sense_a_obs;
        logic signed [15:0] sense_b_obs;
        logic signed [15:0] coarse_obs;
        logic signed [31:0] reward;
        logic               terminated;
        logic               episode_start;
        logic               explore;
        logic [1:0]         random_action;
    } step_t;

    typedef struct packed {
        logic [1:0]             action;
        logic                   new_entry;
        logic                   table_full;
        logic [COUNT_OUT_W-1:0] entries_used;
    } result_t;

    // clamp to +-3.0, scale, round half away from zero, two's complement code
    function automatic logic [7:0] bucket(input logic signed [15:0] v,
                                          input logic [4:0] scale);
        logic signed [15:0] c;
        logic [13:0]        mag;
        logic [18:0]        prod;
        logic [7:0]         r;
        c = v;
        if (v > OBS_LIMIT)
            c = OBS_LIMIT;
        else if (v < -OBS_LIMIT)
            c = -OBS_LIMIT;
        mag  = (c < 0) ? 14'(-c) : 14'(c);
        prod = 19'(mag) * 19'(scale) + 19'd2048;
        r    = 8'(prod >> 12);
        return (c < 0) ? 8'(8'd0 - r) : r;
    endfunction

endpackage

// ===== rtl/tqls_key_gen.sv =====
// state key builder: six bucketed observations packed into one key
// depends on tqls_pkg
module tqls_key_gen (
    input  tqls_pkg::step_t            step,
    output logic [tqls_pkg::KEY_W-1:0] key
);
    import tqls_pkg::*;

    logic [7:0] b0, b1, b2, b3, b4, b5;

    always_comb
    begin
        b0  = bucket(step.progress_obs, 5'd30);
        b1  = bucket(step.vel_a_obs, 5'd12);
        b2  = bucket(step.vel_b_obs, 5'd12);
        b3  = bucket(step.sense_a_obs, 5'd30);
        b4  = bucket(step.sense_b_obs, 5'd30);
        b5  = bucket(step.coarse_obs, 5'd1);
        key = {b5[2:0], b4, b3, b2[6:0], b1[6:0], b0};
    end

endmodule

// ===== rtl/tabular_q_learning_step.sv =====
// top level of the tabular q-learning step block
// depends on tqls_pkg and tqls_key_gen
//
// usage
// - one request on the step channel is one environment step; each request gives
//   exactly one result on the result channel (action, insert and full flags,
//   number of keys held)
// - keys live in a key memory filled in insertion order; lookup is a linear
//   scan, one entry a cycle, over the keys held so far
// - the time from acceptance to a valid result is set by the scan of the key memory,
//   which stops at a hit or runs over all keys held, and by the update states
//   S_PREV_RD to S_WRITE when a value update runs
// - one request is worked on at a time; the next one is accepted the cycle after
//   the previous result has been loaded into the output register
// - a result waits in the output register while the receiver stalls; a finished
//   request waits for that register to free up before it writes its result
// - reset clears the key count, the previous-step slot and the configuration
//   (training on, alpha 4915, gamma 32440); the memories need no clearing pass
//   since only entries below the key count are ever read
// - configuration writes are taken at any time but meant for idle periods
module tabular_q_learning_step #(
    parameter int ENTRIES    = 4096,
    parameter int ACTIONS    = 4,
    parameter int VALUE_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_en,
    input  logic [tqls_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [tqls_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              step_valid,
    output logic                              step_ready,
    input  tqls_pkg::step_t                   step,
    output logic                              result_valid,
    input  logic                              result_ready,
    output tqls_pkg::result_t                 result
);
    import tqls_pkg::*;

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int AW   = (ACTIONS > 1) ? $clog2(ACTIONS) : 1;
    localparam int VB   = VALUE_BITS;
    localparam int RW   = ACTIONS * VB;
    // working width for sums: wide enough for reward, values and their difference
    localparam int SW   = ((VB > 32) ? VB : 32) + 2;
    localparam int MW   = SW + 16;

    localparam logic signed [SW-1:0] VMAX = SW'((64'sd1 <<< (VB - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] VMIN = -VMAX - SW'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_INSERT, S_CUR_RD, S_CUR_CAP, S_PREV_RD,
        S_PREV_CAP, S_TARGET, S_DELTA, S_WRITE, S_DONE
    } state_t;

    // configuration
    logic        train_mode_reg;
    logic [15:0] learning_rate_reg;
    logic [15:0] discount_reg;
    logic [15:0] alpha, gamma;

    // sequencer
    state_t          state_reg, state_next;
    logic [KEY_W-1:0] key_in, key_reg;
    step_t           step_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   scan_idx_reg;
    logic            pend_reg;
    logic [IW-1:0]   pend_idx_reg;
    logic [IW-1:0]   cur_slot_reg;
    logic            slot_ok_reg;
    logic            new_reg;
    logic            full_reg;
    logic [RW-1:0]   cur_q_reg;
    logic [RW-1:0]   prev_row_reg;
    logic signed [SW-1:0] old_reg;
    logic signed [SW-1:0] boot_reg;
    logic signed [SW-1:0] diff_reg;
    logic signed [SW-1:0] delta_reg;
    logic [IW-1:0]   last_slot_reg;
    logic [AW-1:0]   last_action_reg;
    logic            last_valid_reg;
    logic            result_valid_reg;
    result_t         result_reg;

    // memories
    logic [KEY_W-1:0] key_mem [ENTRIES];
    logic [RW-1:0]    q_mem   [ENTRIES];
    logic [KEY_W-1:0] key_rd_data;
    logic [RW-1:0]    q_rd_data;
    logic [IW-1:0]    q_rd_addr;
    logic             q_we;
    logic [IW-1:0]    q_wa;
    logic [RW-1:0]    q_wd;

    // datapath
    logic             issue, hit, do_upd, out_free;
    logic signed [VB-1:0] mx, lane, best_val;
    logic [AW-1:0]    best, act, rnd_m;
    logic [2:0]       rnd_ext;
    logic [VB:0]      mx_mag;
    logic [MW-1:0]    boot_prod;
    logic [SW-1:0]    boot_r;
    logic signed [SW-1:0] target, sum_t, new_val;
    logic [SW-1:0]    diff_mag;
    logic [MW-1:0]    delta_prod;
    logic [SW-1:0]    delta_r;
    logic [RW-1:0]    new_row;

    tqls_key_gen u_key_gen (
        .step (step),
        .key  (key_in)
    );

    assign alpha = (learning_rate_reg > Q_ONE) ? Q_ONE : learning_rate_reg;
    assign gamma = (discount_reg > Q_ONE) ? Q_ONE : discount_reg;

    assign step_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign out_free     = !result_valid_reg || result_ready;

    // scan control: issue while entries remain, compare in the next cycle
    assign issue  = (scan_idx_reg < count_reg);
    assign hit    = pend_reg && (key_rd_data == key_reg);
    assign do_upd = train_mode_reg && !step_reg.episode_start && last_valid_reg;

    function automatic logic [IW-1:0] new_row_addr();
        return (state_reg == S_INSERT) ? count_reg[IW-1:0] : last_slot_reg;
    endfunction

    always_comb
    begin
        q_rd_addr = (state_reg == S_PREV_RD) ? last_slot_reg : cur_slot_reg;
        q_we = 1'b0;
        q_wa = new_row_addr();
        q_wd = new_row;
        if (state_reg == S_INSERT)
        begin
            q_we = 1'b1;
            q_wd = '0;
        end
        else if (state_reg == S_WRITE)
        begin
            q_we = 1'b1;
        end
    end

    // key memory: one read port for the scan, one write port for inserts
    always_ff @(posedge clk)
    begin
        if (state_reg == S_INSERT)
            key_mem[count_reg[IW-1:0]] <= key_reg;
        key_rd_data <= key_mem[scan_idx_reg[IW-1:0]];
    end

    // value memory: one row of all action values per key
    always_ff @(posedge clk)
    begin
        if (q_we)
            q_mem[q_wa] <= q_wd;
        q_rd_data <= q_mem[q_rd_addr];
    end

    // maximum of the current row and the lowest-index greedy choice
    always_comb
    begin
        mx       = signed'(cur_q_reg[VB-1:0]);
        best     = '0;
        best_val = signed'(cur_q_reg[VB-1:0]);
        for (int a = 1; a < ACTIONS; a++)
        begin
            lane = signed'(cur_q_reg[a*VB +: VB]);
            if (lane > best_val)
            begin
                best_val = lane;
                best     = AW'(a);
            end
        end
        mx = best_val;
    end

    // random action modulo the action count (exact from two actions up); used when exploring in training
    always_comb
    begin
        rnd_ext = {1'b0, step_reg.random_action};
        if (ACTIONS < 4 && rnd_ext >= 3'(ACTIONS))
            rnd_ext = rnd_ext - 3'(ACTIONS);
        rnd_m = AW'(rnd_ext);
        act   = (train_mode_reg && step_reg.explore) ? rnd_m : best;
    end

    // gamma * max, rounded half away from zero, zero for a terminal step
    always_comb
    begin
        mx_mag    = (mx < 0) ? (VB+1)'(-(VB+1)'(mx)) : (VB+1)'(mx);
        boot_prod = MW'(mx_mag) * MW'(gamma) + MW'(16384);
        boot_r    = SW'(boot_prod >> 15);
        if (step_reg.terminated)
            boot_r = '0;
        else if (mx < 0)
            boot_r = SW'(0) - boot_r;
    end

    // target saturated, difference to the old value
    always_comb
    begin
        sum_t  = SW'(step_reg.reward) + boot_reg;
        target = (sum_t > VMAX) ? VMAX : ((sum_t < VMIN) ? VMIN : sum_t);
    end

    // alpha * difference, rounded half away from zero
    always_comb
    begin
        diff_mag   = (diff_reg < 0) ? SW'(-diff_reg) : SW'(diff_reg);
        delta_prod = MW'(diff_mag) * MW'(alpha) + MW'(16384);
        delta_r    = SW'(delta_prod >> 15);
        if (diff_reg < 0)
            delta_r = SW'(0) - delta_r;
    end

    // saturated new value merged into the previous row
    always_comb
    begin
        new_val = old_reg + delta_reg;
        if (new_val > VMAX)
            new_val = VMAX;
        else if (new_val < VMIN)
            new_val = VMIN;
        new_row = prev_row_reg;
        new_row[last_action_reg*VB +: VB] = VB'(new_val);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (step_valid)
                    state_next = S_SCAN;
            S_SCAN:
                if (hit)
                    state_next = S_CUR_RD;
                else if (!issue && !pend_reg)
                begin
                    if (train_mode_reg && count_reg < CW'(ENTRIES))
                        state_next = S_INSERT;
                    else
                        state_next = do_upd ? S_PREV_RD : S_DONE;
                end
            S_INSERT:   state_next = do_upd ? S_PREV_RD : S_DONE;
            S_CUR_RD:   state_next = S_CUR_CAP;
            S_CUR_CAP:  state_next = do_upd ? S_PREV_RD : S_DONE;
            S_PREV_RD:  state_next = S_PREV_CAP;
            S_PREV_CAP: state_next = S_TARGET;
            S_TARGET:   state_next = S_DELTA;
            S_DELTA:    state_next = S_WRITE;
            S_WRITE:    state_next = S_DONE;
            S_DONE:
                if (out_free)
                    state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            train_mode_reg    <= TRAIN_MODE_RST;
            learning_rate_reg <= LEARNING_RATE_RST;
            discount_reg      <= DISCOUNT_RST;
            count_reg         <= '0;
            scan_idx_reg      <= '0;
            pend_reg          <= 1'b0;
            last_slot_reg     <= '0;
            last_action_reg   <= '0;
            last_valid_reg    <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_en)
            begin
                unique case (cfg_addr)
                    CFG_TRAIN_MODE:    train_mode_reg    <= cfg_data[0];
                    CFG_LEARNING_RATE: learning_rate_reg <= cfg_data;
                    CFG_DISCOUNT:      discount_reg      <= cfg_data;
                    default:           ;
                endcase
            end

            // a new result loads as the old one leaves, otherwise the old one holds
            result_valid_reg <= ((state_reg == S_DONE) && out_free)
                                || (result_valid_reg && !result_ready);

            case (state_reg)
                S_IDLE:
                    if (step_valid)
                    begin
                        step_reg     <= step;
                        key_reg      <= key_in;
                        scan_idx_reg <= '0;
                        pend_reg     <= 1'b0;
                        slot_ok_reg  <= 1'b0;
                        new_reg      <= 1'b0;
                        full_reg     <= 1'b0;
                        cur_q_reg    <= '0;
                    end
                S_SCAN:
                begin
                    pend_reg     <= issue && !hit;
                    pend_idx_reg <= scan_idx_reg[IW-1:0];
                    if (issue && !hit)
                        scan_idx_reg <= scan_idx_reg + CW'(1);
                    if (hit)
                    begin
                        cur_slot_reg <= pend_idx_reg;
                        slot_ok_reg  <= 1'b1;
                    end
                    else if (!issue && !pend_reg)
                    begin
                        if (train_mode_reg && count_reg >= CW'(ENTRIES))
                            full_reg <= 1'b1;
                    end
                end
                S_INSERT:
                begin
                    cur_slot_reg <= count_reg[IW-1:0];
                    slot_ok_reg  <= 1'b1;
                    new_reg      <= 1'b1;
                    count_reg    <= count_reg + CW'(1);
                end
                S_CUR_CAP:
                    cur_q_reg <= q_rd_data;
                S_PREV_CAP:
                begin
                    prev_row_reg <= q_rd_data;
                    old_reg      <= SW'(signed'(q_rd_data[last_action_reg*VB +: VB]));
                    boot_reg     <= boot_r;
                end
                S_TARGET:
                    diff_reg <= target - old_reg;
                S_DELTA:
                    delta_reg <= delta_r;
                S_WRITE:
                    // same slot: the greedy choice sees the updated value
                    if (slot_ok_reg && last_slot_reg == cur_slot_reg)
                        cur_q_reg[last_action_reg*VB +: VB] <= VB'(new_val);
                S_DONE:
                    if (out_free)
                    begin
                        result_reg.action       <= 2'(act);
                        result_reg.new_entry    <= new_reg;
                        result_reg.table_full   <= full_reg;
                        result_reg.entries_used <= COUNT_OUT_W'(count_reg);
                        last_slot_reg           <= cur_slot_reg;
                        last_action_reg         <= act;
                        last_valid_reg          <= train_mode_reg && slot_ok_reg;
                    end
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/tqls_checker.sv =====
// port-level checks of the tabular q-learning step block, with its bind
// depends on tqls_pkg and tabular_q_learning_step_defines.svh
`include "tabular_q_learning_step_defines.svh"

module tqls_checker #(
    parameter int ENTRIES = 4096
) (
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_ready,
    input tqls_pkg::result_t result
);
    import tqls_pkg::*;

    // a stalled result holds
    `TQLS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

    // an item either inserts or is refused, never both
    `TQLS_ASSERT_IMP(a_new_or_full, result_valid, !(result.new_entry && result.table_full))

    // a refused insert only happens with the table at capacity
    `TQLS_ASSERT_IMP(a_full_count, result_valid && result.table_full,
        result.entries_used == COUNT_OUT_W'(ENTRIES))

    // an insert leaves at least one key held
    `TQLS_ASSERT_IMP(a_new_count, result_valid && result.new_entry, result.entries_used != '0)

endmodule

bind tabular_q_learning_step tqls_checker #(.ENTRIES(ENTRIES)) u_tqls_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
